/* src/fbpa_pkg.sv */
// fbpa_pkg: shared types and constants for the fixed block pool allocator
// no dependencies; imported by every module of the block except fbpa_ram
package fbpa_pkg;

  // operation codes carried in the op field
  localparam logic [1:0] OP_GET  = 2'd0;
  localparam logic [1:0] OP_RET  = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [1:0] REG_ALIGN_LOG2  = 2'd2;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd3;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // reset values of the registers
  localparam logic [31:0] RST_POOL_BASE   = 32'd0;
  localparam logic [15:0] RST_BLOCK_BYTES = 16'd64;
  localparam logic [3:0]  RST_ALIGN_LOG2  = 4'd3;
  localparam logic [8:0]  RST_BLOCK_COUNT = 9'd16;

  // aligned block size needs one bit more than block_bytes
  localparam int unsigned STEP_W = 17;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] block_addr_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] block_addr_out;
    logic        ok;
    logic [8:0]  free_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] pool_base;
    logic [15:0] block_bytes;
    logic [3:0]  align_log2;
    logic [8:0]  block_count;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic pend_fail;   // stage a failed result with the current count
    logic pop;         // read top entry, decrement count
    logic push;        // write returned address, increment count
    logic fill_start;  // latch capacity, stride and base for a refill
    logic fill_step;   // write one refill entry
    logic fill_done;   // last refill entry: set count and pool size
    logic out_load;    // move the staged result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic top_zero;
    logic can_push;
    logic cap_zero;
    logic fill_last;
    logic out_free;
  } stat_t;

  // block_bytes rounded up to a multiple of 2**align_log2
  function automatic logic [STEP_W-1:0] aligned_size(input logic [15:0] bytes,
                                                     input logic [3:0]  align);
    logic [STEP_W-1:0] mask;
    mask = (STEP_W'(1) << align) - STEP_W'(1);
    return (STEP_W'(bytes) + mask) & ~mask;
  endfunction

endpackage

/* src/fixed_block_pool_allocator_unit.sv */
// fixed_block_pool_allocator_unit: top level of the fixed-size block pool allocator
// depends on fbpa_pkg, fbpa_regs, fbpa_ctrl, fbpa_dp (and fbpa_ram below it)

// Hands out fixed-size blocks from a pool kept as a LIFO stack of block
// addresses. An init beat (op 2) refills the stack with pool_base + i*size for
// i below block_count (saturated at MAX_BLOCKS), where size is block_bytes
// rounded up to 2**align_log2; it fails with ok 0 when block_count is zero. A
// get beat (op 0) pops an address, or answers ok 0 and address zero when the
// stack is empty. A return beat (op 1) pushes block_addr_in, or answers ok 0
// when the pool is already full. Every input beat gives exactly one result
// beat carrying the free count after the operation; op 3 is a no-op with ok 0.
// Sequence: a get, return or no-op beat first acts on the stack memory, whose
// read port is registered, and its staged result then moves into the output
// register; init writes one refill entry per block, up to the saturated block
// count, on the single write port before its result is staged, and a refused
// init stages a failed result directly. A new beat is taken while the previous
// result still sits in the output register; a stall on the result channel
// holds the block before it loads the next result. The stack memory is not
// cleared at reset; push and pop bounds keep reads within written entries.
// Configuration registers may be written only while idle.
module fixed_block_pool_allocator_unit
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // register file: pool_base, block_bytes, align_log2, block_count
  fbpa_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: takes a beat only when idle, walks the refill, waits for output
  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack memory, counters, refill address walk and output register
  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .addr_in   (in_data.block_addr_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/fbpa_ram.sv */
// fbpa_ram: generic single-write, single-read memory with registered read
// no dependencies
module fbpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fbpa_regs.sv */
// fbpa_regs: configuration register file behind the apb-style port
// depends on fbpa_pkg
module fbpa_regs
  import fbpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_base   <= RST_POOL_BASE;
      cfg_r.block_bytes <= RST_BLOCK_BYTES;
      cfg_r.align_log2  <= RST_ALIGN_LOG2;
      cfg_r.block_count <= RST_BLOCK_COUNT;
    end else if (wr_en) begin
      case (idx)
        REG_POOL_BASE:   cfg_r.pool_base   <= cfg_pwdata;
        REG_BLOCK_BYTES: cfg_r.block_bytes <= cfg_pwdata[15:0];
        REG_ALIGN_LOG2:  cfg_r.align_log2  <= cfg_pwdata[3:0];
        REG_BLOCK_COUNT: cfg_r.block_count <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POOL_BASE:   cfg_prdata = cfg_r.pool_base;
      REG_BLOCK_BYTES: cfg_prdata = CFG_DATA_W'(cfg_r.block_bytes);
      REG_ALIGN_LOG2:  cfg_prdata = CFG_DATA_W'(cfg_r.align_log2);
      REG_BLOCK_COUNT: cfg_prdata = CFG_DATA_W'(cfg_r.block_count);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* src/fbpa_ctrl.sv */
// fbpa_ctrl: operation sequencer for the allocator
// depends on fbpa_pkg; drives the datapath through cmd_t, watches stat_t
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_PEND
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PEND;
          case (in_op)
            OP_GET: begin
              if (stat.top_zero) cmd.pend_fail = 1'b1;
              else               cmd.pop       = 1'b1;
            end
            OP_RET: begin
              if (stat.can_push) cmd.push      = 1'b1;
              else               cmd.pend_fail = 1'b1;
            end
            OP_INIT: begin
              if (stat.cap_zero) begin
                cmd.pend_fail = 1'b1;
              end else begin
                cmd.fill_start = 1'b1;
                state_nxt      = S_FILL;
              end
            end
            default: cmd.pend_fail = 1'b1;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.fill_done = 1'b1;
          state_nxt     = S_PEND;
        end
      end
      S_PEND: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* src/fbpa_dp.sv */
// fbpa_dp: free stack memory, counters, refill address generator, output register
// depends on fbpa_pkg and fbpa_ram
module fbpa_dp
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic [31:0] addr_in,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned FC_W  = (CNT_W > 9) ? CNT_W : 9;

  logic [CNT_W-1:0]     top_r, size_r, cap_r, cap_nxt, pend_cnt_r;
  logic [IDX_W-1:0]     idx_r;
  logic [ADDR_BITS-1:0] acc_r, step_r;
  logic                 pend_ok_r, pend_ram_r;
  logic                 out_valid_r;
  logic [31:0]          out_addr_r;
  logic                 out_ok_r;
  logic [FC_W-1:0]      out_cnt_r;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ADDR_BITS-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]     top_dec, top_inc;

  assign top_dec = top_r - CNT_W'(1);
  assign top_inc = top_r + CNT_W'(1);

  // capacity saturates at the stack depth
  assign cap_nxt = (32'(cfg.block_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                             : CNT_W'(cfg.block_count);

  assign ram_we    = cmd.push | cmd.fill_step;
  assign ram_waddr = cmd.fill_step ? idx_r : top_r[IDX_W-1:0];
  assign ram_wdata = cmd.fill_step ? acc_r : ADDR_BITS'(addr_in);
  assign ram_re    = cmd.pop;
  assign ram_raddr = top_dec[IDX_W-1:0];

  fbpa_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stack count and pool size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      size_r <= '0;
    end else if (cmd.pop) begin
      top_r <= top_dec;
    end else if (cmd.push) begin
      top_r <= top_inc;
    end else if (cmd.fill_done) begin
      top_r  <= cap_r;
      size_r <= cap_r;
    end
  end

  // refill walk: running address instead of a multiply
  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      idx_r  <= '0;
      cap_r  <= cap_nxt;
      acc_r  <= ADDR_BITS'(cfg.pool_base);
      step_r <= ADDR_BITS'(aligned_size(cfg.block_bytes, cfg.align_log2));
    end else if (cmd.fill_step) begin
      idx_r <= idx_r + IDX_W'(1);
      acc_r <= acc_r + step_r;
    end
  end

  // staged result
  always_ff @(posedge clk) begin
    if (cmd.pend_fail) begin
      pend_ok_r  <= 1'b0;
      pend_ram_r <= 1'b0;
      pend_cnt_r <= top_r;
    end else if (cmd.pop) begin
      pend_ok_r  <= 1'b1;
      pend_ram_r <= 1'b1;
      pend_cnt_r <= top_dec;
    end else if (cmd.push) begin
      pend_ok_r  <= 1'b1;
      pend_ram_r <= 1'b0;
      pend_cnt_r <= top_inc;
    end else if (cmd.fill_done) begin
      pend_ok_r  <= 1'b1;
      pend_ram_r <= 1'b0;
      pend_cnt_r <= cap_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_addr_r <= pend_ram_r ? 32'(ram_rdata) : 32'd0;
      out_ok_r   <= pend_ok_r;
      out_cnt_r  <= FC_W'(pend_cnt_r);
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.block_addr_out = out_addr_r;
  assign out_data.ok             = out_ok_r;
  assign out_data.free_count     = out_cnt_r[8:0];

  assign stat.top_zero  = (top_r == '0);
  assign stat.can_push  = (top_r < size_r);
  assign stat.cap_zero  = (cfg.block_count == 9'd0);
  assign stat.fill_last = (CNT_W'(idx_r) == cap_r - CNT_W'(1));
  assign stat.out_free  = ~out_valid_r | ~out_stall;

endmodule

/* src/fbpa_checker.sv */
// fbpa_checker: port-level checks for the allocator, bound to the top level
// depends on fbpa_pkg and fixed_block_pool_allocator_unit
module fbpa_checker
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a failed operation never hands out an address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.block_addr_out == 32'd0)
    else $error("failed result carries an address");

  // free count never exceeds the stack depth (checked when the depth is at most 511)
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.free_count) <= MAX_BLOCKS || MAX_BLOCKS > 511)
    else $error("free count above stack depth");

  // no result and no input stall right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("activity right after reset");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
